/* rtl/rtcl_pkg.sv */
// ============================================================================
// rtcl_pkg
// Shared types and codes of the range-table colour lookup.
// ============================================================================
`default_nettype none

package rtcl_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int INDEX_W = 10;

    typedef struct packed {
        logic               op;
        logic signed [31:0] sample_value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic        [7:0]  red_in;
        logic        [7:0]  green_in;
        logic        [7:0]  blue_in;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL1 = 4'b0010,
        F_MUL2 = 4'b0100,
        F_PUSH = 4'b1000
    } t_front_state;

    typedef enum logic [3:0] {
        B_CLEAR  = 4'b0001,
        B_IDLE   = 4'b0010,
        B_HINT   = 4'b0100,
        B_SEARCH = 4'b1000
    } t_back_state;

endpackage

`default_nettype wire

/* rtl/rtcl_front.sv */
// ============================================================================
// rtcl_front
// Accepts items and computes the hint bucket of a lookup value by
// reciprocal multiplication, then queues the item.
// ============================================================================
`default_nettype none

module rtcl_front import rtcl_pkg::*; #(
    parameter int HINT_BUCKETS = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire                              i_op,
    input  wire signed [31:0]                i_sample_value,
    input  wire signed [31:0]                i_range_low,
    input  wire signed [31:0]                i_range_high,
    input  wire        [7:0]                 i_red_in,
    input  wire        [7:0]                 i_green_in,
    input  wire        [7:0]                 i_blue_in,
    input  wire                              i_hold,
    output logic                             o_push,
    output t_item                            o_item,
    output logic [$clog2(HINT_BUCKETS)-1:0]  o_bucket,
    input  wire                              i_full
);

    localparam int          HW    = $clog2(HINT_BUCKETS);
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / HINT_BUCKETS);
    localparam logic [16:0] H17   = 17'(HINT_BUCKETS);
    localparam logic [63:0] WRAP  =
        ((64'hFFFF_FFFF_FFFF_FFFF % HINT_BUCKETS) + 64'd1) % HINT_BUCKETS;
    localparam logic [16:0] C17   = 17'(WRAP);

    t_front_state r_state, n_state;
    t_item        r_item;
    logic [48:0]  r_prod1;
    logic [16:0]  r_mag;
    logic         r_neg;
    logic [16:0]  r_prod2;

    logic [32:0]  abs_val;
    logic [16:0]  mag;
    logic [16:0]  quot;
    logic [16:0]  diff;
    logic [16:0]  rem;
    logic [16:0]  bucket;
    logic         accept;

    assign o_stall = !i_rst_n || i_hold || (r_state != F_IDLE);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (r_item.sample_value[31]) begin
            abs_val = 33'd0 - {r_item.sample_value[31], r_item.sample_value};
        end else begin
            abs_val = {1'b0, r_item.sample_value};
        end
        mag  = abs_val[32:16];
        quot = r_prod1[48:32];
        diff = r_mag - r_prod2;
        rem  = (diff >= H17) ? diff - H17 : diff;
        if (r_neg) begin
            bucket = (C17 >= rem) ? C17 - rem : C17 + H17 - rem;
        end else begin
            bucket = rem;
        end
    end

    assign o_item   = r_item;
    assign o_bucket = HW'(bucket);
    assign o_push   = (r_state == F_PUSH) && !i_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = (i_op == OP_LOOKUP) ? F_MUL1 : F_PUSH;
                end
            end
            F_MUL1: n_state = F_MUL2;
            F_MUL2: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op           <= i_op;
            r_item.sample_value <= i_sample_value;
            r_item.range_low    <= i_range_low;
            r_item.range_high   <= i_range_high;
            r_item.red_in       <= i_red_in;
            r_item.green_in     <= i_green_in;
            r_item.blue_in      <= i_blue_in;
        end
        if (r_state == F_MUL1) begin
            r_prod1 <= {32'd0, mag} * {17'd0, RECIP};
            r_mag   <= mag;
            r_neg   <= r_item.sample_value[31] && (mag != 17'd0);
        end
        if (r_state == F_MUL2) begin
            r_prod2 <= 17'({17'd0, quot} * {17'd0, H17});
        end
    end

endmodule

`default_nettype wire

/* rtl/rtcl_queue.sv */
// ============================================================================
// rtcl_queue
// Two-entry queue between the front and the back.
// ============================================================================
`default_nettype none

module rtcl_queue #(
    parameter int DATA_W = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire  [DATA_W-1:0]  i_wdata,
    output logic               o_full,
    input  wire                i_pop,
    output logic [DATA_W-1:0]  o_rdata,
    output logic               o_empty
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

/* rtl/rtcl_back.sv */
// ============================================================================
// rtcl_back
// Executes queued items: appends table entries, walks the table from the
// bucket hint for a matching interval, and holds the result register.
// ============================================================================
`default_nettype none

module rtcl_back import rtcl_pkg::*; #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int HINT_BUCKETS = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_empty,
    input  t_item                            i_item,
    input  wire [$clog2(HINT_BUCKETS)-1:0]   i_bucket,
    output logic                             o_pop,
    output logic                             o_clearing,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic [7:0]                       o_red_out,
    output logic [7:0]                       o_green_out,
    output logic [7:0]                       o_blue_out,
    output logic [1:0]                       o_status,
    output logic [INDEX_W-1:0]               o_matched_index
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HW = $clog2(HINT_BUCKETS);

    logic [63:0]  r_bounds_mem [TABLE_DEPTH];
    logic [23:0]  r_colour_mem [TABLE_DEPTH];
    logic [IW-1:0] r_hint_mem  [HINT_BUCKETS];

    t_back_state        r_state, n_state;
    logic [HW-1:0]      r_clr_idx;
    logic [CW-1:0]      r_count, n_count;
    logic signed [31:0] r_value;
    logic [HW-1:0]      r_bucket;
    logic [IW-1:0]      r_addr, n_addr;
    logic [IW-1:0]      r_checked, n_checked;
    logic [63:0]        r_rd_bounds;
    logic [23:0]        r_rd_colour;
    logic [IW-1:0]      r_rd_hint;

    logic               r_out_valid;
    logic [7:0]         r_out_red, r_out_green, r_out_blue;
    logic [1:0]         r_out_status;
    logic [INDEX_W-1:0] r_out_index;

    logic               out_free;
    logic               emit;
    logic               latch_item;
    logic               bounds_we;
    logic               hint_we;
    logic [HW-1:0]      hint_wa;
    logic [IW-1:0]      hint_wd;
    logic [7:0]         n_out_red, n_out_green, n_out_blue;
    logic [1:0]         n_out_status;
    logic [INDEX_W-1:0] n_out_index;
    logic               table_full;
    logic [IW-1:0]      last_idx;
    logic               hit;

    assign out_free   = !r_out_valid || !i_stall;
    assign table_full = (r_count == CW'(TABLE_DEPTH));
    assign last_idx   = IW'(r_count - 1'b1);
    assign hit        = (r_value >= $signed(r_rd_bounds[63:32])) &&
                        (r_value <  $signed(r_rd_bounds[31:0]));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_checked    = r_checked;
        o_pop        = 1'b0;
        emit         = 1'b0;
        latch_item   = 1'b0;
        bounds_we    = 1'b0;
        hint_we      = 1'b0;
        hint_wa      = r_bucket;
        hint_wd      = r_addr;
        n_out_red    = 8'd0;
        n_out_green  = 8'd0;
        n_out_blue   = 8'd0;
        n_out_status = ST_OK;
        n_out_index  = '0;
        unique case (r_state)
            B_CLEAR: begin
                hint_we = 1'b1;
                hint_wa = r_clr_idx;
                hint_wd = '0;
                if (r_clr_idx == HW'(HINT_BUCKETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_item.op == OP_LOAD) begin
                        emit = 1'b1;
                        if (table_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            bounds_we   = 1'b1;
                            n_count     = r_count + 1'b1;
                            n_out_red   = i_item.red_in;
                            n_out_green = i_item.green_in;
                            n_out_blue  = i_item.blue_in;
                            n_out_index = INDEX_W'(r_count);
                        end
                    end else if (r_count == '0) begin
                        emit         = 1'b1;
                        n_out_status = ST_MISS;
                    end else begin
                        latch_item = 1'b1;
                        n_state    = B_HINT;
                    end
                end
            end
            B_HINT: begin
                n_addr    = r_rd_hint;
                n_checked = '0;
                n_state   = B_SEARCH;
            end
            B_SEARCH: begin
                if (hit || (r_checked == last_idx)) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = B_IDLE;
                        if (hit) begin
                            hint_we     = 1'b1;
                            n_out_red   = r_rd_colour[23:16];
                            n_out_green = r_rd_colour[15:8];
                            n_out_blue  = r_rd_colour[7:0];
                            n_out_index = INDEX_W'(r_addr);
                        end else begin
                            n_out_status = ST_MISS;
                        end
                    end
                end else begin
                    n_addr    = (r_addr == last_idx) ? '0 : r_addr + 1'b1;
                    n_checked = r_checked + 1'b1;
                end
            end
            default: n_state = B_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == B_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_checked <= n_checked;
        if (latch_item) begin
            r_value  <= i_item.sample_value;
            r_bucket <= i_bucket;
        end
        if (emit) begin
            r_out_red    <= n_out_red;
            r_out_green  <= n_out_green;
            r_out_blue   <= n_out_blue;
            r_out_status <= n_out_status;
            r_out_index  <= n_out_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bounds_we) begin
            r_bounds_mem[IW'(r_count)] <= {i_item.range_low, i_item.range_high};
            r_colour_mem[IW'(r_count)] <= {i_item.red_in, i_item.green_in, i_item.blue_in};
        end
        r_rd_bounds <= r_bounds_mem[n_addr];
        r_rd_colour <= r_colour_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (hint_we) begin
            r_hint_mem[hint_wa] <= hint_wd;
        end
        r_rd_hint <= r_hint_mem[i_bucket];
    end

    assign o_clearing      = (r_state == B_CLEAR);
    assign o_valid         = r_out_valid;
    assign o_red_out       = r_out_red;
    assign o_green_out     = r_out_green;
    assign o_blue_out      = r_out_blue;
    assign o_status        = r_out_status;
    assign o_matched_index = r_out_index;

endmodule

`default_nettype wire

/* rtl/range_table_colour_lookup.sv */
// ============================================================================
// range_table_colour_lookup
// Pseudo-colour lookup over a table of Q16.16 intervals with per-bucket
// search hints.
// ============================================================================
//
//  Channel  Handshake                  Payload
//  -------  -------------------------  --------------------------------------
//  in       i_in_valid / o_in_stall    i_op, i_sample_value, i_range_low,
//                                      i_range_high, i_red_in, i_green_in,
//                                      i_blue_in
//  out      o_out_valid / i_out_stall  o_red_out, o_green_out, o_blue_out,
//                                      o_status, o_matched_index
//
//  Front: a load goes straight to the push state; a lookup first passes
//  two multiplier stages for the bucket; then the item waits in a
//  two-entry queue. Back: a load is executed as it is popped; a lookup
//  reads the hint, then checks the entries from the hint on, one a cycle,
//  at most TABLE_DEPTH. After reset the hint memory is cleared, during
//  which no item is accepted.
//  A stalled output holds its result; the front keeps accepting until the
//  queue fills.
// ============================================================================
`default_nettype none

module range_table_colour_lookup import rtcl_pkg::*; #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int HINT_BUCKETS = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire                      i_op,
    input  wire signed [31:0]        i_sample_value,
    input  wire signed [31:0]        i_range_low,
    input  wire signed [31:0]        i_range_high,
    input  wire        [7:0]         i_red_in,
    input  wire        [7:0]         i_green_in,
    input  wire        [7:0]         i_blue_in,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic [7:0]               o_red_out,
    output logic [7:0]               o_green_out,
    output logic [7:0]               o_blue_out,
    output logic [1:0]               o_status,
    output logic [INDEX_W-1:0]       o_matched_index
);

    localparam int HW     = $clog2(HINT_BUCKETS);
    localparam int Q_W    = ITEM_W + HW;

    logic          f_push;
    t_item         f_item;
    logic [HW-1:0] f_bucket;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;
    logic [Q_W-1:0] q_rdata;
    t_item         b_item;
    logic [HW-1:0] b_bucket;
    logic          b_clearing;

    rtcl_front #(
        .HINT_BUCKETS (HINT_BUCKETS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_op           (i_op),
        .i_sample_value (i_sample_value),
        .i_range_low    (i_range_low),
        .i_range_high   (i_range_high),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_hold         (b_clearing),
        .o_push         (f_push),
        .o_item         (f_item),
        .o_bucket       (f_bucket),
        .i_full         (q_full)
    );

    rtcl_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_wdata ({f_bucket, f_item}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign b_item   = q_rdata[ITEM_W-1:0];
    assign b_bucket = q_rdata[Q_W-1:ITEM_W];

    rtcl_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .HINT_BUCKETS (HINT_BUCKETS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_item          (b_item),
        .i_bucket        (b_bucket),
        .o_pop           (q_pop),
        .o_clearing      (b_clearing),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_status        (o_status),
        .o_matched_index (o_matched_index)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_clearing |-> o_in_stall)
        else $error("input open during hint clear");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_MISS ||
                         o_status == ST_FULL))
        else $error("bad status code");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_matched_index == '0 && o_red_out == 8'd0))
        else $error("nonzero payload on failed item");

endmodule

`default_nettype wire
